>>> rtl/core/pis_pkg.sv
// shared constants and types for the inverse permutation scatter block
package pis_pkg;

   localparam int MAX_LEN     = 64;
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(MAX_LEN + 1);
   localparam int CHAR_W      = 8;
   localparam int INDEX_W     = 16;

   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
   localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'd0;

   typedef struct packed {
      logic [CHAR_W-1:0]  ch;
      logic [INDEX_W-1:0] target_index;
   } item_type;

endpackage

>>> rtl/core/pis_channels.sv
// valid/ready channels for the item and decoded character beats
interface pis_req_if;
   logic                                valid;
   logic                                ready;
   logic [pis_pkg::CHAR_W-1:0]          ch;
   logic signed [pis_pkg::INDEX_W-1:0]  target_index;
   logic                                last;

   modport source (output valid, output ch, output target_index, output last, input ready);
   modport sink   (input valid, input ch, input target_index, input last, output ready);
endinterface

interface pis_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pis_pkg::CHAR_W-1:0]  out_char;
   logic [pis_pkg::ADDR_W-1:0]  out_position;
   logic                        out_last;

   modport source (output valid, output out_char, output out_position, output out_last,
                   input ready);
   modport sink   (input valid, input out_char, input out_position, input out_last,
                   output ready);
endinterface

>>> rtl/core/pis_item_store.sv
// item store memory: character and target index per arrival position
module pis_item_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [pis_pkg::ADDR_W-1:0] wr_addr,
   input  pis_pkg::item_type          wr_data,
   input  logic                       rd_en,
   input  logic [pis_pkg::ADDR_W-1:0] rd_addr,
   output pis_pkg::item_type          rd_data
);

   pis_pkg::item_type mem [pis_pkg::STORE_DEPTH];
   pis_pkg::item_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/permutation_inverse_scatter.sv
// top level: collects a scrambled word and emits it in decoded order
// Items are taken one per cycle into the item store until the beat marked last.
// The word is then scattered into the decode buffer (one store read per cycle,
// n = stored items, at most 64, then the final write and the step to leave),
// during which no item is taken, and
// emitted character by character, each read via the single registered read port of
// the decode buffer, then loaded into the output register once it is free. Loading of
// the next word starts as soon as the final character sits in the output register.
module permutation_inverse_scatter (
   input logic     clock,
   input logic     reset,
   pis_req_if.sink   req_chan,
   pis_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      S_LOAD,
      S_SCAT,
      S_EMIT_RD,
      S_EMIT_LD
   } state_type;

   state_type                     state_ff, state_in;
   logic [pis_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [pis_pkg::CNT_W-1:0]     pos_ff, pos_in;
   logic                          sc_vld_ff, sc_vld_in;
   logic [pis_pkg::ADDR_W-1:0]    sc_pos_ff, sc_pos_in;
   logic [pis_pkg::STORE_DEPTH-1:0] wmask_ff, wmask_in;
   logic                          rv_ff, rv_in;
   logic [pis_pkg::CHAR_W-1:0]    rch_ff, rch_in;
   logic [pis_pkg::ADDR_W-1:0]    rpos_ff, rpos_in;
   logic                          rlast_ff, rlast_in;

   logic [pis_pkg::CHAR_W-1:0]    dbuf [pis_pkg::STORE_DEPTH];
   logic [pis_pkg::CHAR_W-1:0]    dq_ff;
   logic                          dv_ff;

   logic                          st_wr_en, st_rd_en;
   pis_pkg::item_type             st_wr_data, st_rd_data;
   logic                          db_wr_en, db_rd_en;
   logic [pis_pkg::ADDR_W-1:0]    db_wr_addr;
   logic                          accept, idx_ok;
   logic [pis_pkg::INDEX_W-1:0]   idx_u;
   logic                          out_free;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rv_ff || rsp_chan.ready;

   assign st_wr_en   = accept && (count_ff < pis_pkg::CNT_W'(pis_pkg::MAX_LEN));
   assign st_wr_data = '{ch: req_chan.ch, target_index: req_chan.target_index};
   assign st_rd_en   = (state_ff == S_SCAT) && (pos_ff < count_ff);

   pis_item_store u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (count_ff[pis_pkg::ADDR_W-1:0]),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (pos_ff[pis_pkg::ADDR_W-1:0]),
      .rd_data (st_rd_data)
   );

   // destination of the stored beat read last cycle
   assign idx_u  = st_rd_data.target_index;
   assign idx_ok = !idx_u[pis_pkg::INDEX_W-1] &&
                   (idx_u < pis_pkg::INDEX_W'(count_ff));
   assign db_wr_en   = sc_vld_ff;
   assign db_wr_addr = idx_ok ? idx_u[pis_pkg::ADDR_W-1:0] : sc_pos_ff;
   assign db_rd_en   = (state_ff == S_EMIT_RD);

   always_ff @(posedge clock) begin
      if (db_wr_en) begin
         dbuf[db_wr_addr] <= st_rd_data.ch;
      end
      if (db_rd_en) begin
         dq_ff <= dbuf[pos_ff[pis_pkg::ADDR_W-1:0]];
         dv_ff <= wmask_ff[pos_ff[pis_pkg::ADDR_W-1:0]];
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      sc_vld_in = 1'b0;
      sc_pos_in = pos_ff[pis_pkg::ADDR_W-1:0];
      wmask_in  = wmask_ff;
      rv_in     = rv_ff && !rsp_chan.ready;
      rch_in    = rch_ff;
      rpos_in   = rpos_ff;
      rlast_in  = rlast_ff;

      if (db_wr_en) begin
         wmask_in[db_wr_addr] = 1'b1;
      end

      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (st_wr_en) begin
                  count_in = count_ff + 1'b1;
               end
               if (req_chan.last) begin
                  wmask_in = '0;
                  pos_in   = '0;
                  state_in = S_SCAT;
               end
            end
         end
         S_SCAT: begin
            if (st_rd_en) begin
               sc_vld_in = 1'b1;
               pos_in    = pos_ff + 1'b1;
            end else if (!sc_vld_ff) begin
               pos_in   = '0;
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rch_in   = (dv_ff && (dq_ff != pis_pkg::NUL_CHAR)) ? dq_ff : pis_pkg::SPACE_CHAR;
               rpos_in  = pos_ff[pis_pkg::ADDR_W-1:0];
               rlast_in = (pos_ff + 1'b1) == count_ff;
               pos_in   = pos_ff + 1'b1;
               if ((pos_ff + 1'b1) == count_ff) begin
                  count_in = '0;
                  state_in = S_LOAD;
               end else begin
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         count_ff  <= '0;
         pos_ff    <= '0;
         sc_vld_ff <= 1'b0;
         wmask_ff  <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
         sc_vld_ff <= sc_vld_in;
         wmask_ff  <= wmask_in;
         rv_ff     <= rv_in;
      end
      sc_pos_ff <= sc_pos_in;
      rch_ff    <= rch_in;
      rpos_ff   <= rpos_in;
      rlast_ff  <= rlast_in;
   end

   assign req_chan.ready        = (state_ff == S_LOAD);
   assign rsp_chan.valid        = rv_ff;
   assign rsp_chan.out_char     = rch_ff;
   assign rsp_chan.out_position = rpos_ff;
   assign rsp_chan.out_last     = rlast_ff;

endmodule
